FILE: rtl/wesm_pkg.sv
// ----------------------------------------------------------------------------
// wesm_pkg
// Shared types and constants for the wheel encoder speed meter.
// ----------------------------------------------------------------------------
package wesm_pkg;

    localparam int TICKS_PER_REV = 6;
    localparam int FRACTION_BITS = 8;

    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 32;
    localparam int CONST_W    = 24;
    localparam int TIMEOUT_W  = 16;
    localparam int POS_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // tick index and divider sizing
    localparam int TICK_IDX_W = (TICKS_PER_REV > 1) ? $clog2(TICKS_PER_REV) : 1;
    localparam int DIVIDEND_W = CONST_W + FRACTION_BITS;
    localparam int DIV_CNT_W  = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    // reset values of the settings
    localparam logic [TIME_W-1:0]    DEBOUNCE_RST = 32'd4000;
    localparam logic [CONST_W-1:0]   CONST_RST    = 24'd7545600;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd5000;

    // setting indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

    // operation codes
    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [TIME_W-1:0] time_us;
        logic [TIME_W-1:0] time_ms;
    } t_in_word;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_fixed;
        logic [TIME_W-1:0]  revolutions;
        logic               edge_accepted;
        logic               speed_cleared;
        logic [POS_W-1:0]   tick_position;
    } t_out_word;

endpackage

FILE: rtl/wheel_encoder_speed_meter.sv
// ----------------------------------------------------------------------------
// wheel_encoder_speed_meter
// Wheel speed from encoder edge periods, with a stall timeout check.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per event:
// an encoder edge with a microsecond stamp, or a timeout check with a
// millisecond stamp. Every input word yields exactly one output word on
// o_out_valid / i_out_ready / o_out_word, carrying speed, revolution count,
// tick position and the edge / clear flags after the update.
// Edge path: accept, debounce compare, period load, then a bit-serial
// restoring divider that shifts out one quotient bit per cycle for all
// DIVIDEND_W = 32 bits, then the result register. A rejected edge or a zero
// period skips the divider; a timeout check is a compare and then the result
// register. One word is in flight at a time; the divider loop sets the rate.
// The per-tick timestamps live in a small single-port memory with a valid
// bit per entry, so reset clears them at once and never-written ticks read 0.
// Reset (synchronous, active low) returns all settings to their defaults and
// clears speed, counters and tick state. If the receiver stalls, the result
// register holds its word and a new input word is still accepted; the next
// result waits in its final state until the register is free.
// Settings are written through i_cfg_we / i_cfg_idx / i_cfg_data by the user
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module wheel_encoder_speed_meter
    import wesm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEBOUNCE,
        S_LOAD,
        S_DIV,
        S_CHECK,
        S_FINISH
    } t_state;

    localparam logic [TICK_IDX_W-1:0] LAST_TICK = TICK_IDX_W'(TICKS_PER_REV - 1);
    localparam logic [TICK_IDX_W-1:0] FIRST_BEFORE = TICK_IDX_W'(1);

    t_state r_state;

    // settings
    logic [TIME_W-1:0]    r_debounce;
    logic [CONST_W-1:0]   r_constant;
    logic [TIMEOUT_W-1:0] r_timeout;

    // block state
    logic [TICK_IDX_W-1:0] r_tick_now;
    logic [TICK_IDX_W-1:0] r_tick_before;
    logic [TIME_W-1:0]     r_revs;
    logic [SPEED_W-1:0]    r_speed;
    logic [SPEED_W-1:0]    r_speed_at_check;
    logic [TIME_W-1:0]     r_next_due;

    // captured word and flags
    logic [TIME_W-1:0]     r_time_us;
    logic [TIME_W-1:0]     r_time_ms;
    logic                  r_acc;
    logic                  r_clr;

    // divider
    logic [TIME_W-1:0]     r_divisor;
    logic [TIME_W-1:0]     r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIV_CNT_W-1:0]  r_div_cnt;

    // output register
    logic                  r_out_valid;
    t_out_word             r_out_word;

    // tick time memory
    logic [TIME_W-1:0]     r_mem [TICKS_PER_REV];
    logic [TICKS_PER_REV-1:0] r_mem_vld;
    logic [TIME_W-1:0]     r_rd_data;
    logic                  r_rd_vld;

    logic [TICK_IDX_W-1:0] rd_addr;
    logic                  mem_we;
    logic [TIME_W-1:0]     stored_time;
    logic [TIME_W-1:0]     elapsed;
    logic [TIME_W:0]       rem_sh;
    logic                  rem_ge;
    logic [TIME_W:0]       rem_diff;
    logic [TIME_W-1:0]     rem_next;
    logic [DIVIDEND_W-1:0] quo_next;
    logic                  out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // read previous tick while idle, current tick afterward
    assign rd_addr     = (r_state == S_IDLE) ? r_tick_before : r_tick_now;
    assign mem_we      = (r_state == S_LOAD);
    assign stored_time = r_rd_vld ? r_rd_data : '0;
    assign elapsed     = r_time_us - stored_time;

    // one restoring division step
    assign rem_sh   = {r_rem, r_quo[DIVIDEND_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_divisor};
    assign rem_ge   = !rem_diff[TIME_W];
    assign rem_next = rem_ge ? rem_diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
    assign quo_next = {r_quo[DIVIDEND_W-2:0], rem_ge};

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tick_now] <= r_time_us;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_mem_vld[r_tick_now] <= 1'b1;
            end
            r_rd_vld <= r_mem_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_debounce       <= DEBOUNCE_RST;
            r_constant       <= CONST_RST;
            r_timeout        <= TIMEOUT_RST;
            r_tick_now       <= '0;
            r_tick_before    <= FIRST_BEFORE;
            r_revs           <= '0;
            r_speed          <= '0;
            r_speed_at_check <= '0;
            r_next_due       <= '0;
            r_time_us        <= '0;
            r_time_ms        <= '0;
            r_acc            <= 1'b0;
            r_clr            <= 1'b0;
            r_divisor        <= '0;
            r_rem            <= '0;
            r_quo            <= '0;
            r_div_cnt        <= '0;
            r_out_valid      <= 1'b0;
            r_out_word       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEBOUNCE: r_debounce <= i_cfg_data[TIME_W-1:0];
                    CFG_CONSTANT: r_constant <= i_cfg_data[CONST_W-1:0];
                    CFG_TIMEOUT:  r_timeout  <= i_cfg_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end

            // S_FINISH reloads the register itself when it is free
            if (r_out_valid && i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_time_us <= i_in_word.time_us;
                        r_time_ms <= i_in_word.time_ms;
                        r_acc     <= 1'b0;
                        r_clr     <= 1'b0;
                        r_state   <= (i_in_word.operation == OP_CHECK) ? S_CHECK
                                                                        : S_DEBOUNCE;
                    end
                end
                S_DEBOUNCE: begin
                    // wrap-safe elapsed time since the previous tick
                    if (elapsed > r_debounce) begin
                        r_acc   <= 1'b1;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_LOAD: begin
                    // rd data now holds this tick's time one revolution ago
                    r_divisor     <= elapsed;
                    r_rem         <= '0;
                    r_quo         <= {r_constant, FRACTION_BITS'(0)};
                    r_div_cnt     <= DIV_CNT_W'(DIVIDEND_W - 1);
                    r_tick_before <= r_tick_now;
                    if (r_tick_now == LAST_TICK) begin
                        r_tick_now <= '0;
                        r_revs     <= r_revs + 1'b1;
                    end else begin
                        r_tick_now <= r_tick_now + 1'b1;
                    end
                    if (elapsed == '0) begin
                        r_speed <= '1;
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem     <= rem_next;
                    r_quo     <= quo_next;
                    r_div_cnt <= r_div_cnt - 1'b1;
                    if (r_div_cnt == '0) begin
                        r_speed <= SPEED_W'(quo_next);
                        r_state <= S_FINISH;
                    end
                end
                S_CHECK: begin
                    // plain compare, not wrap-safe
                    if (r_time_ms > r_next_due) begin
                        if (r_speed == r_speed_at_check) begin
                            r_speed          <= '0;
                            r_speed_at_check <= '0;
                            r_clr            <= 1'b1;
                        end else begin
                            r_speed_at_check <= r_speed;
                        end
                        r_next_due <= r_time_ms + TIME_W'(r_timeout);
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid                <= 1'b1;
                        r_out_word.speed_fixed     <= r_speed;
                        r_out_word.revolutions     <= r_revs;
                        r_out_word.edge_accepted   <= r_acc;
                        r_out_word.speed_cleared   <= r_clr;
                        r_out_word.tick_position   <= POS_W'(r_tick_now);
                        r_state                    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.edge_accepted && o_out_word.speed_cleared))
        else $error("edge and clear flags both set");

    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tick_now <= LAST_TICK) && (r_tick_before <= LAST_TICK))
        else $error("tick index out of range");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_divisor != '0))
        else $error("divider running on zero period");

    a_load_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_state == S_DIV || r_state == S_FINISH))
        else $error("bad state after period load");

    a_check_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> !r_acc)
        else $error("timeout check flagged as edge");
`endif

endmodule
